@@ sv/hsc_pkg.sv @@
// Shared types, constants and lookup functions for the hall six-step commutator.
`timescale 1ns / 1ps

package hsc_pkg;

	localparam int HALL_W     = 3;
	localparam int ON_TIME_W  = 11;
	localparam int BLANK_W    = 10;
	localparam int OFF_TIME_W = 12;
	localparam int TIMER_W    = 12;
	localparam int STEP_W     = 3;
	localparam int DRIVE_W    = 2;
	localparam int POS_W      = 32;
	localparam int PERIOD_OUT_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 72;

	localparam logic [HALL_W-1:0]     HALL_RESET  = 3'b101;
	localparam logic [BLANK_W-1:0]    BLANK_RESET = 10'd50;
	localparam logic [OFF_TIME_W-1:0] OFF_RESET   = 12'd800;
	localparam logic [TIMER_W-1:0]    TIMER_RESET = 12'd50;

	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_TIME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME    = 2'd2;

	localparam logic [DRIVE_W-1:0] DRV_FLOAT = 2'd0;
	localparam logic [DRIVE_W-1:0] DRV_HIGH  = 2'd1;
	localparam logic [DRIVE_W-1:0] DRV_LOW   = 2'd2;

	typedef enum logic [1:0] {
		MODE_BLANK = 2'd0,
		MODE_DRIVE = 2'd1,
		MODE_OFF   = 2'd2
	} phase_mode_t;

	typedef struct packed {
		logic                  reverse_dir;
		logic [BLANK_W-1:0]    blank_time;
		logic [OFF_TIME_W-1:0] off_time;
	} cfg_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] phase_a;
		logic [DRIVE_W-1:0] phase_b;
		logic [DRIVE_W-1:0] phase_c;
		logic [STEP_W-1:0]  step;
		logic [POS_W-1:0]   position;
	} comm_res_t;

	typedef struct packed {
		logic              valid;
		logic [STEP_W-1:0] step;
	} step_dec_t;

	// Hall code is {A, B, C}; the all-low and all-high codes decode as invalid.
	function automatic step_dec_t decode_step(input logic rev, input logic [HALL_W-1:0] code);
		step_dec_t d;
		d.valid = 1'b1;
		case (code)
			3'b101: d.step = rev ? 3'd3 : 3'd0;
			3'b001: d.step = rev ? 3'd4 : 3'd1;
			3'b011: d.step = rev ? 3'd5 : 3'd2;
			3'b010: d.step = rev ? 3'd0 : 3'd3;
			3'b110: d.step = rev ? 3'd1 : 3'd4;
			3'b100: d.step = rev ? 3'd2 : 3'd5;
			default: begin
				d.valid = 1'b0;
				d.step  = 3'd0;
			end
		endcase
		return d;
	endfunction

	// Returns {A, B, C} drive codes for a step.
	function automatic logic [3*DRIVE_W-1:0] step_pattern(input logic [STEP_W-1:0] step);
		logic [3*DRIVE_W-1:0] p;
		case (step)
			3'd0: p = {DRV_HIGH,  DRV_FLOAT, DRV_LOW};
			3'd1: p = {DRV_FLOAT, DRV_HIGH,  DRV_LOW};
			3'd2: p = {DRV_LOW,   DRV_HIGH,  DRV_FLOAT};
			3'd3: p = {DRV_LOW,   DRV_FLOAT, DRV_HIGH};
			3'd4: p = {DRV_FLOAT, DRV_LOW,   DRV_HIGH};
			3'd5: p = {DRV_HIGH,  DRV_LOW,   DRV_FLOAT};
			default: p = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
		endcase
		return p;
	endfunction

endpackage

@@ sv/hall_six_step_commutator_top.sv @@
// Top level: stream ports, configuration registers, input and result registers.
// A beat accepted into the input register has its result written into the result register
// when that register next advances; while the result side stalls, the beat waits in place.
// Throughput: one beat per cycle while the result side is not stalled; the state update is
// a single pass of decode, timer and counter logic between the input and result registers.
// Reset: arst_n clears both stage valids, sets the halls to A1 B0 C1, blanking with a 50-tick
// timer, and the configuration to forward, 50 blanking ticks and 800 off ticks.
`timescale 1ns / 1ps

module hall_six_step_commutator_top #(
	parameter int PERIOD_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// bits: hall_a, hall_b, hall_c, on_time_us[10:0], zero pad
	input  logic [hsc_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// bits: phase_a_drive[1:0], phase_b_drive[1:0], phase_c_drive[1:0], step_index[2:0],
	// position_count[31:0], period_ticks[23:0], zero pad
	output logic [hsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// bits: period_new
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [hsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import hsc_pkg::*;

	cfg_t                    cfg_q;
	logic                    v_s1;
	logic [HALL_W-1:0]       hall_s1;
	logic [ON_TIME_W-1:0]    on_time_s1;
	logic [HALL_W-1:0]       hall_prev_q;
	logic [HALL_W-1:0]       changed;
	logic                    adv2;
	logic                    step_en;
	logic                    load1;
	comm_res_t               comm_res;
	logic [PERIOD_WIDTH-1:0] latch_next;
	logic [PERIOD_OUT_W-1:0] period24;
	logic                    period_new;
	logic                    v_s2;
	comm_res_t               res_s2;
	logic [PERIOD_OUT_W-1:0] period_s2;
	logic                    period_new_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_dir <= 1'b0;
			cfg_q.blank_time  <= BLANK_RESET;
			cfg_q.off_time    <= OFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REVERSE_DIR: cfg_q.reverse_dir <= cfg_data[0];
				REG_BLANK_TIME:  cfg_q.blank_time  <= cfg_data[BLANK_W-1:0];
				REG_OFF_TIME:    cfg_q.off_time    <= cfg_data[OFF_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// The result register frees up when empty or taken; the input register moves with it.
	assign adv2     = !v_s2 || m_tready;
	assign step_en  = v_s1 && adv2;
	assign s_tready = !v_s1 || adv2;
	assign load1    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			hall_s1    <= {s_tdata[0], s_tdata[1], s_tdata[2]};
			on_time_s1 <= s_tdata[HALL_W+ON_TIME_W-1:HALL_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_prev_q <= HALL_RESET;
		end else if (step_en) begin
			hall_prev_q <= hall_s1;
		end
	end

	assign changed = hall_s1 ^ hall_prev_q;

	hsc_commutate u_commutate (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (step_en),
		.hall_code    (hall_s1),
		.hall_changed (changed),
		.on_time      (on_time_s1),
		.cfg          (cfg_q),
		.res          (comm_res)
	);

	hsc_period #(
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_period (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (step_en),
		.b_changed  (changed[1]),
		.latch_next (latch_next),
		.period_new (period_new)
	);

	generate
		if (PERIOD_WIDTH >= PERIOD_OUT_W) begin : g_period_trunc
			assign period24 = latch_next[PERIOD_OUT_W-1:0];
		end else begin : g_period_ext
			assign period24 = {{(PERIOD_OUT_W-PERIOD_WIDTH){1'b0}}, latch_next};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2        <= comm_res;
			period_s2     <= period24;
			period_new_s2 <= period_new;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = period_new_s2;
	assign m_tdata  = {
		{(OUT_TDATA_W - 3*DRIVE_W - STEP_W - POS_W - PERIOD_OUT_W){1'b0}},
		period_s2,
		res_s2.position,
		res_s2.step,
		res_s2.phase_c,
		res_s2.phase_b,
		res_s2.phase_a
	};

	// While driving, exactly one phase floats and the other two are driven.
	a_two_phases_driven: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_s2.phase_a != DRV_FLOAT || res_s2.phase_b != DRV_FLOAT
			|| res_s2.phase_c != DRV_FLOAT))
		|-> ($countones({res_s2.phase_a == DRV_FLOAT, res_s2.phase_b == DRV_FLOAT,
			res_s2.phase_c == DRV_FLOAT}) == 1))
		else $error("drive pattern does not float exactly one phase");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.step <= 3'd5))
		else $error("step index out of range");

	// A held input beat must not be overwritten while the result side stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> (v_s1 && $stable(hall_s1) && $stable(on_time_s1)))
		else $error("input register changed during a stall");

	// A taken result with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !v_s1) |=> !m_tvalid)
		else $error("result beat repeated");

	// The hall history only moves when a beat passes into the result register.
	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(hall_prev_q))
		else $error("hall history changed without a beat");

endmodule

@@ sv/hsc_period.sv @@
// Hall B period measurement with a saturating counter.
`timescale 1ns / 1ps

module hsc_period #(
	parameter int PERIOD_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    b_changed,
	output logic [PERIOD_WIDTH-1:0] latch_next,
	output logic                    period_new
);
	import hsc_pkg::*;

	logic                    measuring_q;
	logic [PERIOD_WIDTH-1:0] counter_q;
	logic [PERIOD_WIDTH-1:0] latch_q;
	logic [PERIOD_WIDTH-1:0] cnt_inc;
	logic [PERIOD_WIDTH-1:0] counter_next;
	logic                    measuring_next;

	always_comb begin
		cnt_inc = counter_q;
		if (measuring_q && (counter_q != {PERIOD_WIDTH{1'b1}})) begin
			cnt_inc = counter_q + {{(PERIOD_WIDTH-1){1'b0}}, 1'b1};
		end
		counter_next   = cnt_inc;
		measuring_next = measuring_q;
		latch_next     = latch_q;
		period_new     = 1'b0;
		if (b_changed) begin
			if (!measuring_q) begin
				measuring_next = 1'b1;
				counter_next   = '0;
			end else begin
				measuring_next = 1'b0;
				latch_next     = cnt_inc;
				period_new     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
			counter_q   <= '0;
			latch_q     <= '0;
		end else if (en) begin
			measuring_q <= measuring_next;
			counter_q   <= counter_next;
			latch_q     <= latch_next;
		end
	end

endmodule

@@ sv/hsc_commutate.sv @@
// Step decode, blanking and drive/off pulse sequencing, and hall A position count.
`timescale 1ns / 1ps

module hsc_commutate (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [hsc_pkg::HALL_W-1:0]       hall_code,
	input  logic [hsc_pkg::HALL_W-1:0]       hall_changed,
	input  logic [hsc_pkg::ON_TIME_W-1:0]    on_time,
	input  hsc_pkg::cfg_t                    cfg,
	output hsc_pkg::comm_res_t               res
);
	import hsc_pkg::*;

	phase_mode_t         mode_q;
	phase_mode_t         mode_next;
	logic [TIMER_W-1:0]  timer_q;
	logic [TIMER_W-1:0]  timer_next;
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_next;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    pos_next;
	step_dec_t           dec;
	logic [3*DRIVE_W-1:0] pattern;

	assign dec = decode_step(cfg.reverse_dir, hall_code);

	// Step and position follow a hall change; a rise on A counts by the new B level.
	always_comb begin
		step_next = step_q;
		pos_next  = pos_q;
		if (hall_changed != '0) begin
			if (dec.valid) begin
				step_next = dec.step;
			end
			if (hall_changed[2] && hall_code[2]) begin
				pos_next = hall_code[1] ? pos_q + 32'd1 : pos_q - 32'd1;
			end
		end
	end

	// Next mode and timer.
	always_comb begin
		mode_next  = mode_q;
		timer_next = timer_q;
		if (hall_changed != '0) begin
			mode_next  = MODE_BLANK;
			timer_next = {{(TIMER_W-BLANK_W){1'b0}}, cfg.blank_time};
		end else if (timer_q > {{(TIMER_W-1){1'b0}}, 1'b1}) begin
			timer_next = timer_q - {{(TIMER_W-1){1'b0}}, 1'b1};
		end else begin
			case (mode_q)
				MODE_DRIVE: begin
					mode_next  = MODE_OFF;
					timer_next = cfg.off_time;
				end
				default: begin
					mode_next  = MODE_DRIVE;
					timer_next = {{(TIMER_W-ON_TIME_W){1'b0}}, on_time};
				end
			endcase
		end
	end

	assign pattern = step_pattern(step_next);

	// Phase outputs for the mode after this beat's update.
	always_comb begin
		res.step     = step_next;
		res.position = pos_next;
		case (mode_next)
			MODE_DRIVE: begin
				res.phase_a = pattern[3*DRIVE_W-1:2*DRIVE_W];
				res.phase_b = pattern[2*DRIVE_W-1:DRIVE_W];
				res.phase_c = pattern[DRIVE_W-1:0];
			end
			default: begin
				res.phase_a = DRV_FLOAT;
				res.phase_b = DRV_FLOAT;
				res.phase_c = DRV_FLOAT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BLANK;
			timer_q <= TIMER_RESET;
			step_q  <= '0;
			pos_q   <= '0;
		end else if (en) begin
			mode_q  <= mode_next;
			timer_q <= timer_next;
			step_q  <= step_next;
			pos_q   <= pos_next;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking hall six-step commutator testbench: directed decode and zero-length tests, then random motion.
`timescale 1ns / 1ps

module testbench;
	import hsc_pkg::*;

	localparam int PERIOD_W = 24;

	typedef struct packed {
		logic [DRIVE_W-1:0]      phase_a;
		logic [DRIVE_W-1:0]      phase_b;
		logic [DRIVE_W-1:0]      phase_c;
		logic [STEP_W-1:0]       step;
		logic [POS_W-1:0]        position;
		logic [PERIOD_OUT_W-1:0] period;
		logic                    period_new;
	} tick_out_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tuser;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	hall_six_step_commutator_top #(.PERIOD_WIDTH(PERIOD_W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Commutator model state, mirrored from the block.
	logic                    cfg_reverse = 1'b0;
	logic [BLANK_W-1:0]      cfg_blank   = BLANK_RESET;
	logic [OFF_TIME_W-1:0]   cfg_off     = OFF_RESET;
	logic [HALL_W-1:0]       hall_last   = HALL_RESET;
	logic [STEP_W-1:0]       step_now    = '0;
	phase_mode_t             mode_now    = MODE_BLANK;
	logic [TIMER_W-1:0]      mode_timer  = TIMER_RESET;
	logic [POS_W-1:0]        pos_count   = '0;
	logic                    meas_active = 1'b0;
	logic [PERIOD_W-1:0]     meas_count  = '0;
	logic [PERIOD_W-1:0]     meas_latch  = '0;

	// Hall code {A,B,C} to step; -1 marks the all-low and all-high codes.
	int fwd_step [8] = '{-1, 1, 3, 2, 5, 0, 4, -1};
	int rev_step [8] = '{-1, 4, 0, 5, 2, 3, 1, -1};
	logic [DRIVE_W-1:0] drive_of [6][3] = '{
		'{DRV_HIGH,  DRV_FLOAT, DRV_LOW},
		'{DRV_FLOAT, DRV_HIGH,  DRV_LOW},
		'{DRV_LOW,   DRV_HIGH,  DRV_FLOAT},
		'{DRV_LOW,   DRV_FLOAT, DRV_HIGH},
		'{DRV_FLOAT, DRV_LOW,   DRV_HIGH},
		'{DRV_HIGH,  DRV_LOW,   DRV_FLOAT}
	};
	// Hall codes in forward rotation order.
	logic [HALL_W-1:0] rotation [6] = '{3'b101, 3'b001, 3'b011, 3'b010, 3'b110, 3'b100};

	tick_out_t expected_ticks [$];
	int        fail_count = 0;
	bit        gap_en   = 1'b1;
	bit        stall_en = 1'b1;
	int        rot_idx  = 0;
	int        rot_dir  = 1;
	tick_out_t got_tick;
	tick_out_t want_tick;

	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic predict_tick(input logic [HALL_W-1:0] code, input logic [ON_TIME_W-1:0] on_time,
			output tick_out_t r);
		logic [HALL_W-1:0] diff;
		int s;
		diff = code ^ hall_last;
		r = '0;
		if (meas_active && meas_count != {PERIOD_W{1'b1}})
			meas_count = meas_count + 1'b1;
		// Each hall B change either starts the count from zero or, while counting, latches it and flags period_new.
		if (diff[1]) begin
			if (!meas_active) begin
				meas_active = 1'b1;
				meas_count  = '0;
			end else begin
				meas_latch   = meas_count;
				meas_active  = 1'b0;
				r.period_new = 1'b1;
			end
		end
		if (diff != '0) begin
			if (diff[2] && code[2])
				pos_count = code[1] ? pos_count + 1 : pos_count - 1;
			s = cfg_reverse ? rev_step[code] : fwd_step[code];
			if (s >= 0)
				step_now = s[STEP_W-1:0];
			mode_now   = MODE_BLANK;
			mode_timer = TIMER_W'(cfg_blank);
		end else if (mode_timer > 1) begin
			mode_timer = mode_timer - 1'b1;
		end else if (mode_now == MODE_DRIVE) begin
			mode_now   = MODE_OFF;
			mode_timer = cfg_off;
		end else begin
			mode_now   = MODE_DRIVE;
			mode_timer = TIMER_W'(on_time);
		end
		hall_last = code;
		if (mode_now == MODE_DRIVE) begin
			r.phase_a = drive_of[step_now][0];
			r.phase_b = drive_of[step_now][1];
			r.phase_c = drive_of[step_now][2];
		end
		r.step     = step_now;
		r.position = pos_count;
		r.period   = meas_latch[PERIOD_OUT_W-1:0];
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_tick(input logic [HALL_W-1:0] code, input logic [ON_TIME_W-1:0] on_time);
		tick_out_t r;
		if (gap_en && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tdata  = {2'b00, on_time, code[0], code[1], code[2]};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		predict_tick(code, on_time, r);
		expected_ticks.push_back(r);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		s_tvalid  = 1'b0;
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_REVERSE_DIR: cfg_reverse = value[0];
			REG_BLANK_TIME:  cfg_blank   = value[BLANK_W-1:0];
			REG_OFF_TIME:    cfg_off     = value[OFF_TIME_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic rev, input int blank, input int off);
		wait_drained();
		write_reg(REG_REVERSE_DIR, CFG_DATA_W'(rev));
		write_reg(REG_BLANK_TIME, CFG_DATA_W'(blank));
		write_reg(REG_OFF_TIME, CFG_DATA_W'(off));
	endtask

	// Mostly clean rotation with random dwell, direction reversals and the odd glitch code.
	task automatic run_motion(input int n_items, input int dwell_max, input int on_max);
		int sent;
		int dwell;
		int pick;
		logic [HALL_W-1:0] code;
		logic [ON_TIME_W-1:0] on_time;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				code = HALL_W'($urandom_range(0, 7));
			end else begin
				if (pick < 4)
					rot_dir = -rot_dir;
				rot_idx = (rot_idx + rot_dir + 6) % 6;
				code = rotation[rot_idx];
			end
			pick = $urandom_range(0, 9);
			if (pick < 6)
				dwell = $urandom_range(0, 3);
			else if (pick < 9)
				dwell = $urandom_range(0, dwell_max);
			else
				dwell = $urandom_range(0, 3 * dwell_max);
			repeat (dwell + 1) begin
				if ($urandom_range(0, 4) == 0)
					on_time = ON_TIME_W'($urandom_range(0, 2047));
				else
					on_time = ON_TIME_W'($urandom_range(0, on_max));
				send_tick(code, on_time);
				sent++;
			end
		end
	endtask

	// Every hall code under the reset settings, invalid codes and a multi-hall jump included.
	task automatic test_decode_forward();
		send_tick(3'b101, 11'd2047);
		send_tick(3'b001, 11'd0);
		send_tick(3'b011, 11'd2047);
		send_tick(3'b010, 11'd0);
		send_tick(3'b110, 11'd1365);
		send_tick(3'b100, 11'd682);
		send_tick(3'b101, 11'd0);
		send_tick(3'b000, 11'd0);
		send_tick(3'b111, 11'd0);
		send_tick(3'b010, 11'd0);
	endtask

	task automatic test_decode_reverse();
		set_timing(1'b1, 0, 0);
		send_tick(3'b011, 11'd1);
		send_tick(3'b001, 11'd1);
		send_tick(3'b101, 11'd1);
		send_tick(3'b100, 11'd1);
		send_tick(3'b110, 11'd1);
		send_tick(3'b010, 11'd1);
		send_tick(3'b111, 11'd1);
	endtask

	// Zero-length blanking, drive and off intervals each last one tick.
	task automatic test_zero_lengths();
		set_timing(1'b0, 0, 0);
		send_tick(3'b101, 11'd0);
		send_tick(3'b101, 11'd0);
		send_tick(3'b101, 11'd2);
		send_tick(3'b101, 11'd0);
		send_tick(3'b101, 11'd0);
		send_tick(3'b101, 11'd0);
	endtask

	task automatic test_reset_timing_motion();
		set_timing(1'b0, 50, 800);
		run_motion(200, 80, 20);
	endtask

	task automatic test_reverse_short_times();
		set_timing(1'b1, 0, 0);
		run_motion(200, 12, 6);
	endtask

	task automatic test_long_times();
		set_timing(1'b0, 1023, 4095);
		run_motion(120, 30, 20);
		set_timing(1'b1, 1, 4095);
		run_motion(80, 20, 10);
	endtask

	task automatic test_random_times();
		set_timing(1'b1, $urandom_range(0, 15), $urandom_range(0, 15));
		run_motion(120, 25, 10);
		// Hold off the sender until the block has delivered everything.
		wait_drained();
		set_timing(1'b0, $urandom_range(0, 15), $urandom_range(0, 15));
		run_motion(120, 25, 10);
	endtask

	task automatic test_steady_stream();
		set_timing(1'b0, 3, 7);
		gap_en   = 1'b0;
		stall_en = 1'b0;
		run_motion(200, 20, 8);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_decode_forward();
		test_decode_reverse();
		test_zero_lengths();
		test_reset_timing_motion();
		test_reverse_short_times();
		test_long_times();
		test_random_times();
		test_steady_stream();
		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && expected_ticks.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_en && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			m_tready = arst_n;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_tick.phase_a    = m_tdata[1:0];
			got_tick.phase_b    = m_tdata[3:2];
			got_tick.phase_c    = m_tdata[5:4];
			got_tick.step       = m_tdata[8:6];
			got_tick.position   = m_tdata[40:9];
			got_tick.period     = m_tdata[64:41];
			got_tick.period_new = m_tuser;
			if (expected_ticks.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result beat %p", $realtime, got_tick);
			end else begin
				want_tick = expected_ticks.pop_front();
				if (got_tick.phase_a !== want_tick.phase_a
						|| got_tick.phase_b !== want_tick.phase_b
						|| got_tick.phase_c !== want_tick.phase_c
						|| got_tick.step !== want_tick.step
						|| got_tick.position !== want_tick.position
						|| got_tick.period !== want_tick.period
						|| got_tick.period_new !== want_tick.period_new) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: mismatch", $realtime);
						$display("  expected %p", want_tick);
						$display("  actual   %p", got_tick);
					end
				end
			end
		end
	end

endmodule

@@ sim.f @@
sv/hsc_pkg.sv
sv/hsc_period.sv
sv/hsc_commutate.sv
sv/hall_six_step_commutator_top.sv
tb/sv/testbench.sv
